// File: hw/rtl/fopi_pkg.sv
// Shared constants and region codes for the file offset to index path mapper.
package fopi_pkg;

    localparam int DIRECT_SLOTS_DEF    = 12;
    localparam int INDIRECT_LEVELS_DEF = 3;
    localparam int ENTRY_BYTES_DEF     = 4;

    localparam int OFF_W   = 48;
    localparam int CB_W    = 17;
    localparam int HB_W    = 12;
    localparam int P_W     = 16;
    localparam int IDX_W   = 14;
    localparam int COFF_W  = 16;
    localparam int BND_W   = 50;
    localparam int DEPTH_W = 3;
    localparam int SLOT_W  = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CB_W-1:0] CLUSTER_MIN   = 17'd512;
    localparam logic [CB_W-1:0] CLUSTER_MAX   = 17'd65536;
    localparam logic [CB_W-1:0] CLUSTER_RESET = 17'd4096;
    localparam logic [HB_W-1:0] HEADER_RESET  = 12'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b1;

    localparam logic [DEPTH_W-1:0] DEPTH_NODE   = 3'b111;
    localparam logic [DEPTH_W-1:0] DEPTH_DIRECT = 3'd0;

    localparam int REGION_W = 3;
    localparam logic [REGION_W-1:0] RGN_MINUS  = 3'd0;
    localparam logic [REGION_W-1:0] RGN_NODE   = 3'd1;
    localparam logic [REGION_W-1:0] RGN_DIRECT = 3'd2;
    localparam logic [REGION_W-1:0] RGN_TREE1  = 3'd3;
    localparam logic [REGION_W-1:0] RGN_TREE2  = 3'd4;
    localparam logic [REGION_W-1:0] RGN_TREE3  = 3'd5;
    localparam logic [REGION_W-1:0] RGN_FAIL   = 3'd6;

endpackage

// File: hw/rtl/fopi_div.sv
// Pipelined restoring divider with elastic stages and a side payload.
module fopi_div #(
    parameter int NW   = 48,
    parameter int DW   = 17,
    parameter int PW   = 19,
    parameter int STEP = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] in_num,
    input  logic [PW-1:0] in_pay,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [PW-1:0] out_pay
);

    localparam int NST = (NW + STEP - 1) / STEP;
    localparam int EW  = NST * STEP;

    // shifts dividend bits out of the top of n and quotient bits in at the bottom
    function automatic logic [EW+DW-1:0] div_steps(input logic [EW-1:0] num,
                                                   input logic [DW-1:0] rem,
                                                   input logic [DW-1:0] d);
        logic [EW-1:0] n;
        logic [DW-1:0] r;
        logic [DW:0]   t;
        n = num;
        r = rem;
        for (int i = 0; i < STEP; i++) begin
            t = {r, n[EW-1]};
            n = {n[EW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                n[0] = 1'b1;
            end
            r = t[DW-1:0];
        end
        return {n, r};
    endfunction

    logic          v_reg [NST];
    logic [EW-1:0] n_reg [NST];
    logic [DW-1:0] r_reg [NST];
    logic [PW-1:0] p_reg [NST];
    logic [NST:0]  rdy;

    assign rdy[NST]  = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_quo   = n_reg[NST-1][NW-1:0];
    assign out_rem   = r_reg[NST-1];
    assign out_pay   = p_reg[NST-1];

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic          vin;
        logic [EW-1:0] nin;
        logic [DW-1:0] rin;
        logic [PW-1:0] pin;
        logic [EW-1:0] n_next;
        logic [DW-1:0] r_next;

        if (k == 0) begin : g_first
            assign vin = in_valid;
            assign nin = EW'(in_num);
            assign rin = '0;
            assign pin = in_pay;
        end else begin : g_next
            assign vin = v_reg[k-1];
            assign nin = n_reg[k-1];
            assign rin = r_reg[k-1];
            assign pin = p_reg[k-1];
        end

        assign {n_next, r_next} = div_steps(nin, rin, divisor);
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
                p_reg[k] <= pin;
            end
        end
    end

endmodule

// File: hw/rtl/file_offset_to_index_path.sv
// Top level of the file offset to index path mapper.
// Maps one 48-bit file byte offset per cycle to its index path: node cluster
// (depth -1), direct slot (depth 0) or indirect tree of one to three levels,
// plus the byte offset inside the target cluster. The path runs through 7
// front stages, a classify stage, a subtract stage, three restoring divider
// chains of 12, 10 and 9 stages (4 quotient bits per stage, by cluster size,
// then twice by entries per cluster) and the output register. Throughput is
// one word per cycle while the result side is ready; stages are elastic,
// so bubbles are squeezed out while the result side stalls. Region bounds are
// derived from the configuration in a 7-register chain that the front stages
// match, so a register write applies to every word accepted after it. There
// is no clearing pass after reset.
module file_offset_to_index_path import fopi_pkg::*; #(
    parameter int DIRECT_SLOTS    = DIRECT_SLOTS_DEF,
    parameter int INDIRECT_LEVELS = INDIRECT_LEVELS_DEF,
    parameter int ENTRY_BYTES     = ENTRY_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // byte_offset[47:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // depth[2:0], slot[6:3], level_one_index[20:7], level_two_index[34:21],
    // level_three_index[48:35], cluster_offset[64:49], zero fill[71:65]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,   // fail[0]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CB_W-1:0]        cfg_data
);

    localparam int PRE  = 7;
    localparam int RSH  = 24;
    localparam int DS_W = CB_W + 5;
    localparam logic [RSH-1:0] RECIP = RSH'((2 ** RSH + ENTRY_BYTES - 1) / ENTRY_BYTES);
    localparam int PAY1 = REGION_W + COFF_W;
    localparam int PAY2 = PAY1 + COFF_W + IDX_W;
    localparam int PAY3 = PAY2 + 2 * IDX_W;
    localparam int Q0_W = 39;
    localparam int Q1_W = 33;
    localparam logic [BND_W-1:0] SPAN_SAT = BND_W'(49'h1_0000_0000_0000);

    // ---------------- configuration ----------------
    logic [CB_W-1:0] cfg_c_reg;
    logic [HB_W-1:0] cfg_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_c_reg <= CLUSTER_RESET;
            cfg_h_reg <= HEADER_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CLUSTER: cfg_c_reg <= cfg_data;
                CFG_HEADER:  cfg_h_reg <= cfg_data[HB_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- derived bounds, free running ----------------
    logic [CB_W-1:0]       c1_reg;
    logic [HB_W-1:0]       h1_reg;
    logic [CB_W+RSH-1:0]   prod2_reg;
    logic [CB_W-1:0]       noidx2_reg;
    logic [DS_W-1:0]       dlen2_reg;
    logic [COFF_W-1:0]     hm1_2_reg;
    logic [P_W-1:0]        p3_reg;
    logic [BND_W-1:0]      dend3_reg;
    logic [CB_W+P_W-1:0]   span1_4_reg;
    logic [BND_W-1:0]      end1_5_reg;
    logic [OFF_W:0]        span2_5_reg;
    logic [BND_W-1:0]      end2_6_reg;
    logic [BND_W-1:0]      span3_6_reg;
    logic [BND_W-1:0]      end3_7_reg;

    logic [CB_W-1:0]       c_clamp;
    logic [HB_W-1:0]       h_clamp;
    logic [OFF_W+P_W-1:0]  m6;

    always_comb begin
        if (cfg_c_reg < CLUSTER_MIN) begin
            c_clamp = CLUSTER_MIN;
        end else if (cfg_c_reg > CLUSTER_MAX) begin
            c_clamp = CLUSTER_MAX;
        end else begin
            c_clamp = cfg_c_reg;
        end
        if ({5'b0, cfg_h_reg} >= c_clamp) begin
            h_clamp = HB_W'(c_clamp - 17'd1);
        end else begin
            h_clamp = cfg_h_reg;
        end
    end

    assign m6 = {{P_W{1'b0}}, span2_5_reg[OFF_W-1:0]} * {{OFF_W{1'b0}}, p3_reg};

    always_ff @(posedge aclk) begin
        c1_reg      <= c_clamp;
        h1_reg      <= h_clamp;
        prod2_reg   <= {{RSH{1'b0}}, c1_reg} * {{CB_W{1'b0}}, RECIP};
        noidx2_reg  <= c1_reg - {5'b0, h1_reg};
        dlen2_reg   <= {5'b0, c1_reg} * DS_W'(DIRECT_SLOTS);
        hm1_2_reg   <= {4'b0, h1_reg} - 16'd1;
        p3_reg      <= prod2_reg[RSH +: P_W];
        dend3_reg   <= BND_W'(noidx2_reg) + BND_W'(dlen2_reg);
        span1_4_reg <= {{P_W{1'b0}}, c1_reg} * {{CB_W{1'b0}}, p3_reg};
        end1_5_reg  <= dend3_reg + BND_W'(span1_4_reg);
        span2_5_reg <= (OFF_W+1)'({{P_W{1'b0}}, span1_4_reg} * {{(CB_W+P_W){1'b0}}, p3_reg});
        end2_6_reg  <= end1_5_reg + BND_W'(span2_5_reg);
        span3_6_reg <= (span2_5_reg[OFF_W] || (|m6[OFF_W+P_W-1:OFF_W]))
                       ? SPAN_SAT : BND_W'(m6[OFF_W-1:0]);
        end3_7_reg  <= end2_6_reg + span3_6_reg;
    end

    // ---------------- elastic control chain ----------------
    logic             out_v_reg;
    logic             out_rdy;
    logic             d1_in_ready, d1_out_valid;
    logic             d2_in_ready, d2_out_valid;
    logic             d3_in_ready, d3_out_valid;
    logic             cls_rdy, sub_rdy;
    logic [PRE:0]     prdy;

    assign out_rdy  = !out_v_reg || m_tready;
    assign prdy[PRE] = cls_rdy;
    assign s_tready = prdy[0];

    // ---------------- front stages ----------------
    logic             pv_reg   [PRE];
    logic [OFF_W-1:0] poff_reg [PRE];

    for (genvar k = 0; k < PRE; k++) begin : g_pre
        logic             vin;
        logic [OFF_W-1:0] din;
        if (k == 0) begin : g_first
            assign vin = s_tvalid;
            assign din = s_tdata[OFF_W-1:0];
        end else begin : g_next
            assign vin = pv_reg[k-1];
            assign din = poff_reg[k-1];
        end
        assign prdy[k] = !pv_reg[k] || prdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pv_reg[k] <= 1'b0;
            end else if (prdy[k]) begin
                pv_reg[k] <= vin;
            end
        end
        always_ff @(posedge aclk) begin
            if (prdy[k]) begin
                poff_reg[k] <= din;
            end
        end
    end

    // ---------------- classify ----------------
    logic                cv_reg;
    logic [REGION_W-1:0] crgn_reg;
    logic [OFF_W-1:0]    coff_reg;
    logic [REGION_W-1:0] rgn_next;
    logic [BND_W-1:0]    off_x;

    assign off_x   = BND_W'(poff_reg[PRE-1]);
    assign cls_rdy = !cv_reg || sub_rdy;

    always_comb begin
        if (poff_reg[PRE-1] == '1) begin
            rgn_next = RGN_MINUS;
        end else if (off_x < BND_W'(noidx2_reg)) begin
            rgn_next = RGN_NODE;
        end else if (off_x < dend3_reg) begin
            rgn_next = RGN_DIRECT;
        end else if (off_x < end1_5_reg) begin
            rgn_next = RGN_TREE1;
        end else if (INDIRECT_LEVELS >= 2 && off_x < end2_6_reg) begin
            rgn_next = RGN_TREE2;
        end else if (INDIRECT_LEVELS >= 3 && off_x < end3_7_reg) begin
            rgn_next = RGN_TREE3;
        end else begin
            rgn_next = RGN_FAIL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= 1'b0;
        end else if (cls_rdy) begin
            cv_reg <= pv_reg[PRE-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (cls_rdy) begin
            crgn_reg <= rgn_next;
            coff_reg <= poff_reg[PRE-1];
        end
    end

    // ---------------- subtract region base ----------------
    logic                sv_reg;
    logic [REGION_W-1:0] srgn_reg;
    logic [COFF_W-1:0]   soff_reg;
    logic [OFF_W-1:0]    sr_reg;
    logic [OFF_W-1:0]    base;

    assign sub_rdy = !sv_reg || d1_in_ready;

    always_comb begin
        case (crgn_reg)
            RGN_DIRECT: base = OFF_W'(noidx2_reg);
            RGN_TREE1:  base = dend3_reg[OFF_W-1:0];
            RGN_TREE2:  base = end1_5_reg[OFF_W-1:0];
            RGN_TREE3:  base = end2_6_reg[OFF_W-1:0];
            default:    base = coff_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
        end else if (sub_rdy) begin
            sv_reg <= cv_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (sub_rdy) begin
            srgn_reg <= crgn_reg;
            soff_reg <= coff_reg[COFF_W-1:0];
            sr_reg   <= coff_reg - base;
        end
    end

    // ---------------- divider chains ----------------
    logic [OFF_W-1:0] quo1;
    logic [CB_W-1:0]  rem1_0;
    logic [PAY1-1:0]  pay1;
    logic [Q0_W-1:0]  quo2;
    logic [P_W-1:0]   rem2_0;
    logic [PAY2-1:0]  pay2;
    logic [Q1_W-1:0]  quo3;
    logic [P_W-1:0]   rem3_0;
    logic [PAY3-1:0]  pay3;

    fopi_div #(.NW(OFF_W), .DW(CB_W), .PW(PAY1), .STEP(4)) u_div_cluster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sv_reg),
        .in_ready  (d1_in_ready),
        .in_num    (sr_reg),
        .in_pay    ({srgn_reg, soff_reg}),
        .divisor   (c1_reg),
        .out_valid (d1_out_valid),
        .out_ready (d2_in_ready),
        .out_quo   (quo1),
        .out_rem   (rem1_0),
        .out_pay   (pay1)
    );

    fopi_div #(.NW(Q0_W), .DW(P_W), .PW(PAY2), .STEP(4)) u_div_entry1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d1_out_valid),
        .in_ready  (d2_in_ready),
        .in_num    (quo1[Q0_W-1:0]),
        .in_pay    ({pay1, rem1_0[COFF_W-1:0], quo1[IDX_W-1:0]}),
        .divisor   (p3_reg),
        .out_valid (d2_out_valid),
        .out_ready (d3_in_ready),
        .out_quo   (quo2),
        .out_rem   (rem2_0),
        .out_pay   (pay2)
    );

    fopi_div #(.NW(Q1_W), .DW(P_W), .PW(PAY3), .STEP(4)) u_div_entry2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d2_out_valid),
        .in_ready  (d3_in_ready),
        .in_num    (quo2[Q1_W-1:0]),
        .in_pay    ({pay2, quo2[IDX_W-1:0], rem2_0[IDX_W-1:0]}),
        .divisor   (p3_reg),
        .out_valid (d3_out_valid),
        .out_ready (out_rdy),
        .out_quo   (quo3),
        .out_rem   (rem3_0),
        .out_pay   (pay3)
    );

    // ---------------- assemble result ----------------
    logic [REGION_W-1:0] f_rgn;
    logic [COFF_W-1:0]   f_off, f_rem0;
    logic [IDX_W-1:0]    f_q0, f_q1, f_rem1, f_q2, f_rem2;

    assign {f_rgn, f_off, f_rem0, f_q0, f_q1, f_rem1} = pay3;
    assign f_q2   = quo3[IDX_W-1:0];
    assign f_rem2 = rem3_0[IDX_W-1:0];

    logic               fail_next;
    logic [DEPTH_W-1:0] depth_next;
    logic [SLOT_W-1:0]  slot_next;
    logic [IDX_W-1:0]   l1_next, l2_next, l3_next;
    logic [COFF_W-1:0]  cof_next;

    always_comb begin
        fail_next  = 1'b0;
        depth_next = DEPTH_DIRECT;
        slot_next  = '0;
        l1_next    = '0;
        l2_next    = '0;
        l3_next    = '0;
        cof_next   = '0;
        case (f_rgn)
            RGN_MINUS: begin
                depth_next = DEPTH_NODE;
                cof_next   = hm1_2_reg;
            end
            RGN_NODE: begin
                depth_next = DEPTH_NODE;
                cof_next   = f_off + {4'b0, h1_reg};
            end
            RGN_DIRECT: begin
                slot_next = f_q0[SLOT_W-1:0];
                cof_next  = f_rem0;
            end
            RGN_TREE1: begin
                depth_next = 3'd1;
                l1_next    = f_q0;
                cof_next   = f_rem0;
            end
            RGN_TREE2: begin
                depth_next = 3'd2;
                slot_next  = 4'd1;
                l1_next    = f_q1;
                l2_next    = f_rem1;
                cof_next   = f_rem0;
            end
            RGN_TREE3: begin
                depth_next = 3'd3;
                slot_next  = 4'd2;
                l1_next    = f_q2;
                l2_next    = f_rem2;
                l3_next    = f_rem1;
                cof_next   = f_rem0;
            end
            RGN_FAIL: begin
                fail_next = 1'b1;
            end
            default: ;
        endcase
    end

    logic               fail_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [IDX_W-1:0]   l1_reg, l2_reg, l3_reg;
    logic [COFF_W-1:0]  cof_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_rdy) begin
            out_v_reg <= d3_out_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            fail_reg  <= fail_next;
            depth_reg <= depth_next;
            slot_reg  <= slot_next;
            l1_reg    <= l1_next;
            l2_reg    <= l2_next;
            l3_reg    <= l3_next;
            cof_reg   <= cof_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = fail_reg;
    assign m_tdata  = {7'b0, cof_reg, l3_reg, l2_reg, l1_reg, slot_reg, depth_reg};

endmodule

// File: hw/rtl/fopi_checker.sv
// Port-level checker for the offset mapper, bound to the top level.
module fopi_checker import fopi_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("failed mapping carries nonzero fields");

    a_node_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == DEPTH_NODE |-> m_tdata[48:3] == '0 && !m_tuser)
        else $error("node cluster result has slot or indices");

    a_direct_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[2:0] == DEPTH_DIRECT |-> m_tdata[48:7] == '0)
        else $error("direct result has indices");

endmodule

bind file_offset_to_index_path fopi_checker u_fopi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/tb_file_offset_to_index_path.sv
// Testbench for the file offset to index path mapper: directed and random offsets.
module tb_file_offset_to_index_path import fopi_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                fail;
        logic [DEPTH_W-1:0]  depth;
        logic [SLOT_W-1:0]   slot;
        logic [IDX_W-1:0]    idx1;
        logic [IDX_W-1:0]    idx2;
        logic [IDX_W-1:0]    idx3;
        logic [COFF_W-1:0]   coff;
    } path_t;

    localparam longint unsigned MINUS_ONE = 48'hFFFF_FFFF_FFFF;
    localparam int DSLOTS = DIRECT_SLOTS_DEF;
    localparam int EBYTES = ENTRY_BYTES_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CB_W-1:0] cfg_data = '0;

    longint unsigned cluster_sz = 4096;
    longint unsigned header_sz = 128;
    path_t expected_paths[$];
    int errors = 0;

    file_offset_to_index_path dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic path_t map_offset(longint unsigned off);
        path_t r;
        longint unsigned c, h, p, lim, base, span, rem, dv;
        longint unsigned ix[3];
        c = cluster_sz;
        h = header_sz;
        r = '0;
        if (c < 512) c = 512;
        if (c > 65536) c = 65536;
        if (h >= c) h = c - 1;
        p = c / EBYTES;
        if (off == MINUS_ONE) begin
            r.depth = DEPTH_NODE;
            r.coff = COFF_W'(h - 1);
            return r;
        end
        lim = c - h;
        if (off < lim) begin
            r.depth = DEPTH_NODE;
            r.coff = COFF_W'(off + h);
            return r;
        end
        if (off < lim + DSLOTS * c) begin
            rem = off - lim;
            r.depth = DEPTH_DIRECT;
            r.slot = SLOT_W'(rem / c);
            r.coff = COFF_W'(rem % c);
            return r;
        end
        base = lim + DSLOTS * c;
        span = c * p;
        for (int t = 0; t < 3; t++) begin
            if (off < base + span) begin
                rem = off - base;
                ix = '{0, 0, 0};
                for (int j = 0; j <= t; j++) begin
                    dv = c;
                    for (int k = 0; k < t - j; k++) dv = dv * p;
                    ix[j] = rem / dv;
                    rem = rem % dv;
                end
                r.depth = DEPTH_W'(t + 1);
                r.slot = SLOT_W'(t);
                r.idx1 = IDX_W'(ix[0]);
                r.idx2 = IDX_W'(ix[1]);
                r.idx3 = IDX_W'(ix[2]);
                r.coff = COFF_W'(rem);
                return r;
            end
            base += span;
            span *= p;
        end
        r.fail = 1'b1;
        return r;
    endfunction

    // region bounds under the current registers, used to aim offsets
    function automatic longint unsigned region_start(int rgn);
        longint unsigned c, h, p, b, span;
        c = cluster_sz;
        h = header_sz;
        if (c < 512) c = 512;
        if (c > 65536) c = 65536;
        if (h >= c) h = c - 1;
        p = c / EBYTES;
        b = 0;
        if (rgn >= 1) b = c - h;
        if (rgn >= 2) b += DSLOTS * c;
        span = c * p;
        for (int t = 0; t < rgn - 2; t++) begin
            b += span;
            span *= p;
        end
        return b;
    endfunction

    // valid stays up between words unless an idle gap is drawn
    task automatic send_offset(longint unsigned off);
        int idle;
        idle = $urandom_range(0, 6);
        off = off & MINUS_ONE;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        expected_paths.push_back(map_offset(off));
        s_tvalid <= 1'b1;
        s_tdata <= off[47:0];
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_paths.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CB_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_CLUSTER) cluster_sz = val & 17'h1FFFF;
        else header_sz = val & 12'hFFF;
    endtask

    task automatic send_edges();
        longint unsigned b;
        for (int rgn = 1; rgn <= 5; rgn++) begin
            b = region_start(rgn);
            send_offset(b - 1);
            send_offset(b);
        end
    endtask

    task automatic test_directed();
        send_offset(0);
        send_offset(MINUS_ONE);
        send_offset(48'hFFFF_FFFF_FFFE);
        send_offset(48'h5555_5555_5555);
        send_offset(48'hAAAA_AAAA_AAAA);
        send_edges();
        wait_drained();
    endtask

    task automatic test_random(int n);
        int rgn;
        longint unsigned lo, hi, off;
        for (int i = 0; i < n; i++) begin
            rgn = $urandom_range(0, 6);
            if (rgn == 6) begin
                off = {$urandom, $urandom};
                off = off & MINUS_ONE;
            end else begin
                lo = region_start(rgn);
                hi = region_start(rgn + 1);
                if (hi > MINUS_ONE) hi = MINUS_ONE;
                if (lo >= hi) begin
                    off = hi;
                end else begin
                    off = {$urandom, $urandom};
                    off = lo + off % (hi - lo);
                end
            end
            send_offset(off);
        end
    endtask

    task automatic test_configs();
        longint unsigned cl[6] = '{512, 65536, 4096, 1000, 100, 131071};
        longint unsigned hd[6] = '{0, 4095, 511, 999, 300, 1};
        for (int k = 0; k < 6; k++) begin
            write_reg(CFG_CLUSTER, cl[k]);
            write_reg(CFG_HEADER, hd[k]);
            send_offset(MINUS_ONE);
            send_edges();
            test_random(150);
            wait_drained();
        end
    endtask

    // result side: stall for a drawn number of cycles after each word
    initial begin
        path_t got, exp_p;
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.fail = m_tuser;
                got.depth = m_tdata[2:0];
                got.slot = m_tdata[6:3];
                got.idx1 = m_tdata[20:7];
                got.idx2 = m_tdata[34:21];
                got.idx3 = m_tdata[48:35];
                got.coff = m_tdata[64:49];
                if (expected_paths.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    exp_p = expected_paths.pop_front();
                    if (got !== exp_p || m_tdata[71:65] !== '0) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_p, got);
                        errors++;
                    end
                end
                hold = $urandom_range(0, 6);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("tb_file_offset_to_index_path: errors");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(200);
        wait_drained();
        test_configs();
        if (errors == 0 && expected_paths.size() == 0)
            $display("tb_file_offset_to_index_path: clean");
        else
            $display("tb_file_offset_to_index_path: errors");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/fopi_pkg.sv
hw/rtl/fopi_div.sv
hw/rtl/file_offset_to_index_path.sv
hw/rtl/fopi_checker.sv
bench/tb_file_offset_to_index_path.sv
